### src/tuh5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tuh5_pkg;

    localparam int COUNT_W = 13;
    localparam int LEN_W = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] HEADER_LEN = 13'd4;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } rx_item_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       payload_byte;
        logic             packet_end;
        logic [1:0]       status;
        logic [2:0]       sequence_number;
        logic [2:0]       ack_number;
        logic             reliable_flag;
        logic [3:0]       type_code;
        logic [LEN_W-1:0] length_field;
    } res_item_t;

    // Byte-wise CRC-16-CCITT update, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c[7:0] = c[7:0] ^ d;
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

`default_nettype wire

### src/tuh5_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tuh5_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire tuh5_pkg::rx_item_t  item,
    output logic                     produce,
    output tuh5_pkg::res_item_t      result
);
    import tuh5_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [23:0]        header_reg, header_next;
    logic               sum_good_reg, sum_good_next;
    logic [15:0]        crc_reg, crc_next;
    logic [15:0]        trailer_reg, trailer_next;

    logic [COUNT_W-1:0] idx;
    logic [7:0]         d;
    logic [7:0]         b0, b1, b2;
    logic [7:0]         hdr_sum;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] pay_end;
    logic [COUNT_W-1:0] expect_last;
    logic               crc_on;
    logic               in_crc;
    logic               payload;
    logic [1:0]         status;

    always_comb
    begin
        idx = count_reg;
        d = item.data_byte;
        header_next = header_reg;
        if (idx < 13'd3)
        begin
            unique case (idx[1:0])
                2'd0:    header_next[7:0] = d;
                2'd1:    header_next[15:8] = d;
                default: header_next[23:16] = d;
            endcase
        end
        b0 = header_next[7:0];
        b1 = header_next[15:8];
        b2 = header_next[23:16];
        len = {b2, b1[7:4]};
        crc_on = b0[6];
        pay_end = {1'b0, len} + HEADER_LEN;
        in_crc = idx < pay_end;
        payload = (idx >= HEADER_LEN) && in_crc;

        hdr_sum = b0 + b1 + b2 + d;
        sum_good_next = (idx == 13'd3) ? (hdr_sum == 8'h00) : sum_good_reg;
        crc_next = in_crc ? crc16_byte(crc_reg, d) : crc_reg;
        trailer_next = {d, trailer_reg[15:8]};
        count_next = (count_reg != COUNT_MAX) ? count_reg + 13'd1 : count_reg;

        expect_last = {1'b0, len} + 13'd3 + (crc_on ? 13'd2 : 13'd0);
        if (idx < 13'd3)
            status = STATUS_SHORT;
        else if (idx != expect_last)
            status = STATUS_BAD;
        else if (!sum_good_next)
            status = STATUS_BAD;
        else if (crc_on && (trailer_next != crc_next))
            status = STATUS_BAD;
        else
            status = STATUS_OK;

        produce = payload || item.last_byte;
        result.byte_valid = payload;
        result.payload_byte = payload ? d : 8'h00;
        result.packet_end = item.last_byte;
        result.status = item.last_byte ? status : STATUS_OK;
        result.sequence_number = b0[2:0];
        result.ack_number = b0[5:3];
        result.reliable_flag = b0[7];
        result.type_code = b1[3:0];
        result.length_field = len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            header_reg <= '0;
            sum_good_reg <= 1'b0;
            crc_reg <= CRC_INIT;
            trailer_reg <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                count_reg <= '0;
                header_reg <= '0;
                sum_good_reg <= 1'b0;
                crc_reg <= CRC_INIT;
                trailer_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                header_reg <= header_next;
                sum_good_reg <= sum_good_next;
                crc_reg <= crc_next;
                trailer_reg <= trailer_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> count_reg == '0 && crc_reg == CRC_INIT)
        else $error("Packet state not cleared after the last byte.");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.last_byte && count_reg != COUNT_MAX
        |=> count_reg == $past(count_reg) + 13'd1)
        else $error("Byte counter did not advance by one.");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        produce && !item.last_byte |-> result.status == STATUS_OK)
        else $error("Error status on a result that does not end a packet.");

    a_payload_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        produce && result.byte_valid |-> count_reg >= HEADER_LEN)
        else $error("Payload byte reported inside the header.");

endmodule

`default_nettype wire

### src/three_wire_uart_packet_checker.sv
// Channel   Direction  Payload       Accepted when
// rx        in         rx_item_t     rx_valid && rx_ready
// res       out        res_item_t    res_valid && res_ready
//
// One byte per cycle unless res stalls: a byte is taken into an input register, decoded
// against the per-packet state in one pass, and its result (if any) lands in the result
// register, so a result reaches res through both registers; bytes that give no result
// leave none. While a result waits, one more byte can enter an empty input register, and
// after that rx_ready stays low until the waiting result is taken.
// Reset clears the packet state (count, header, CRC) and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module three_wire_uart_packet_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rx_valid,
    output logic                     rx_ready,
    input  wire tuh5_pkg::rx_item_t  rx_item,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output tuh5_pkg::res_item_t      res_item
);
    import tuh5_pkg::*;

    logic      stage_valid_reg;
    rx_item_t  stage_item_reg;
    logic      out_valid_reg;
    res_item_t out_item_reg;

    logic      advance;
    logic      produce;
    res_item_t result;

    assign advance = stage_valid_reg && (!out_valid_reg || res_ready);
    assign rx_ready = !stage_valid_reg || advance;
    assign res_valid = out_valid_reg;
    assign res_item = out_item_reg;

    tuh5_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (stage_item_reg),
        .produce (produce),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_ready)
                stage_valid_reg <= rx_valid;
            if (advance)
                out_valid_reg <= produce;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
            stage_item_reg <= rx_item;
        if (advance && produce)
            out_item_reg <= result;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_ready |=> out_valid_reg && out_item_reg == $past(out_item_reg))
        else $error("Waiting result was overwritten.");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg && stage_item_reg == $past(stage_item_reg))
        else $error("Stalled item left the input register.");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> rx_ready)
        else $error("Input stalled with an empty result register.");

endmodule

`default_nettype wire
